/* rtl/mvcc_timestamp_oracle_top_defines.svh */
// Assertion macros for the timestamp oracle.
// Used by mvcc_timestamp_oracle_top; expects clk and rst in scope.
`ifndef MVCC_TIMESTAMP_ORACLE_TOP_DEFINES_SVH
`define MVCC_TIMESTAMP_ORACLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MVCCTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVCCTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mvccto_pkg.sv */
// Shared types and command codes for the timestamp oracle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mvccto_pkg;

  localparam int STAMP_W = 64;
  localparam int IDX_W   = 6;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   release_index;
    logic [STAMP_W-1:0] target_stamp;
  } req_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [IDX_W-1:0]   granted_index;
    logic               granted;
    logic [STAMP_W-1:0] clock_now;
    logic [STAMP_W-1:0] oldest_active;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

/* rtl/mvccto_slot_ram.sv */
// Slot table storage: one write port, one registered read port.
// Uses mvccto_pkg for the stamp width.
`timescale 1ns / 1ps
`default_nettype none
module mvccto_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [mvccto_pkg::STAMP_W-1:0] wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [mvccto_pkg::STAMP_W-1:0] rdata
);
  import mvccto_pkg::*;

  logic [STAMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/mvcc_timestamp_oracle_top.sv */
// Transaction timestamp oracle: logical clock plus active-slot table.
// Depends on mvccto_pkg, mvccto_slot_ram and the assertion macro header.
//
// Usage:
//   Command channel: drive req and raise start; the transaction is taken at
//   a clock edge where start is high and busy is low. busy stays high until
//   the result has been produced.
//   Result channel: done pulses for exactly one cycle with rsp valid. The
//   receiver cannot stall; it must capture rsp in that cycle.
// Scan:
//   Every command scans the whole slot table once through the single read
//   port of the slot memory, one slot per cycle, feeding one shared
//   compare unit that finds the lowest free slot and the oldest stamp.
//   After the last slot the block passes through ST_DONE, which registers
//   rsp and done; the next command can be accepted in the cycle done is
//   high, so a new command is never taken while one is in progress.
// Reset:
//   rst (synchronous) sets the clock to 1 and starts a clearing pass that
//   writes every slot free, one slot a cycle; busy is high during that pass.
`timescale 1ns / 1ps
`default_nettype none
module mvcc_timestamp_oracle_top #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mvccto_pkg::req_t  req,
  output logic                   done,
  output mvccto_pkg::rsp_t       rsp
);
  import mvccto_pkg::*;
  `include "mvcc_timestamp_oracle_top_defines.svh"

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);

  state_t             state;
  logic [CW-1:0]      iss;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [CMD_W-1:0]   cmd_q;
  logic [IDX_W-1:0]   rel_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [STAMP_W-1:0] clock;
  logic [STAMP_W-1:0] clock_next;
  logic [STAMP_W-1:0] minv;
  logic               found;
  logic [IW-1:0]      free_idx;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [STAMP_W-1:0] ram_wdata;
  logic [STAMP_W-1:0] ram_rdata;

  logic               rel_hit;
  logic [IW-1:0]      rel_ix;
  logic               grant;
  logic [STAMP_W-1:0] slot_val;
  logic [STAMP_W-1:0] fin_min;

  assign busy    = (state != ST_IDLE);
  assign rel_hit = (cmd_q == CMD_RELEASE) && (32'(rel_q) < 32'(SLOT_COUNT));
  assign rel_ix  = IW'(rel_q);
  assign grant   = (cmd_q == CMD_BEGIN) && found;

  // Released slot counts as free during the scan.
  assign slot_val = (rel_hit && (rd_idx == rel_ix)) ? '0 : ram_rdata;

  assign fin_min = (grant && (stamp_q != '0) && (stamp_q < minv)) ? stamp_q : minv;

  always_comb begin
    clock_next = clock;
    case (req.cmd)
      CMD_BEGIN, CMD_COMMIT: clock_next = clock + STAMP_W'(1);
      CMD_ADVANCE: begin
        if (clock < req.target_stamp) begin
          clock_next = req.target_stamp;
        end
      end
      default: clock_next = clock;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = iss[IW-1:0];
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_DONE: begin
        if (grant) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = stamp_q;
        end else if (rel_hit) begin
          ram_we    = 1'b1;
          ram_waddr = rel_ix;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  mvccto_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      iss    <= '0;
      rd_vld <= 1'b0;
      clock  <= STAMP_W'(1);
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == ST_SCAN) && (iss < FULL_CNT);
      rd_idx <= iss[IW-1:0];
      unique case (state)
        ST_CLEAR: begin
          if (iss == LAST_CNT) begin
            iss   <= '0;
            state <= ST_IDLE;
          end else begin
            iss <= iss + CW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q    <= req.cmd;
            rel_q    <= req.release_index;
            stamp_q  <= (req.cmd == CMD_BEGIN || req.cmd == CMD_COMMIT) ? clock : '0;
            clock    <= clock_next;
            minv     <= clock_next;
            found    <= 1'b0;
            free_idx <= '0;
            iss      <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (iss < FULL_CNT) begin
            iss <= iss + CW'(1);
          end
          if (rd_vld) begin
            if (slot_val == '0) begin
              if (!found) begin
                found    <= 1'b1;
                free_idx <= rd_idx;
              end
            end else if (slot_val < minv) begin
              minv <= slot_val;
            end
            if (rd_idx == LAST_IDX) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          rsp.stamp         <= stamp_q;
          rsp.granted       <= grant;
          rsp.granted_index <= grant ? IDX_W'(free_idx) : '0;
          rsp.clock_now     <= clock;
          rsp.oldest_active <= fin_min;
          done              <= 1'b1;
          iss               <= '0;
          state             <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MVCCTO_ASSERT_NEXT(a_accept_scans, start && !busy, state == ST_SCAN, "accept did not start scan")
  `MVCCTO_ASSERT_NOW(a_oldest_bound, done, rsp.oldest_active <= rsp.clock_now, "oldest above clock")
  `MVCCTO_ASSERT_NOW(a_idx_zero, done && !rsp.granted, rsp.granted_index == '0, "index without grant")
  `MVCCTO_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than one cycle")

endmodule
`default_nettype wire
